// ----- hw/rtl/ilo_pkg.sv -----
// ilo_pkg: shared widths, codes and types of the interval locate/offset block.
// Used by ilo_front, ilo_back and interval_locate_offset_core. No dependencies.
`default_nettype none

package ilo_pkg;

  localparam int DEF_MAX_INTERVALS = 4096;
  localparam int DEF_POS_BITS      = 32;

  localparam int TAG_W   = 12;
  localparam int SLOT_W  = 12;
  localparam int COUNT_W = 13;
  localparam int LEN_W   = 32;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int Q_DEPTH = 2;

  // register index, taken from paddr[ADDR_W-1]
  localparam logic REG_INTERVAL_COUNT = 1'b0;
  localparam logic REG_TOTAL_LENGTH   = 1'b1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOCATE,
    OP_DROP
  } ilo_op_t;

  typedef struct packed {
    ilo_op_t           op;
    logic              oor;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } ilo_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DOWN,
    BK_UP,
    BK_DONE
  } ilo_bk_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ilo_front.sv -----
// ilo_front: accepts input items, classifies them and queues them for the back end.
// Depends on ilo_pkg.
`default_nettype none

module ilo_front #(
  parameter int MAX_INTERVALS = ilo_pkg::DEF_MAX_INTERVALS,
  parameter int POS_BITS      = ilo_pkg::DEF_POS_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        in_cmd,
  input  wire logic [ilo_pkg::SLOT_W-1:0]  in_entry_index,
  input  wire logic [POS_BITS-1:0]         in_position,
  input  wire logic [ilo_pkg::TAG_W-1:0]   in_query_tag,
  input  wire logic [ilo_pkg::LEN_W-1:0]   total_length,
  output      logic                        q_valid,
  input  wire logic                        q_ready,
  output      ilo_pkg::ilo_cmd_t           q_cmd,
  output      logic [POS_BITS-1:0]         q_pos
);
  import ilo_pkg::*;

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int XW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int LW    = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;
  localparam int QPW   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNTW  = $clog2(Q_DEPTH + 1);

  logic [XW:0]          slot_ext;
  logic [LW-1:0]        len_ext;
  logic [POS_BITS-1:0]  len_eff;
  ilo_cmd_t             cls;

  ilo_cmd_t             cmd_mem [Q_DEPTH];
  logic [POS_BITS-1:0]  pos_mem [Q_DEPTH];
  logic [QPW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]      fill_r, fill_nxt;
  logic                 push, pop;

  // classify: loads beyond the table are dropped, queries checked against the length
  always_comb begin
    slot_ext = (XW + 1)'(in_entry_index);
    len_ext  = LW'(total_length);
    len_eff  = len_ext[POS_BITS-1:0];
    cls.slot = in_entry_index;
    cls.tag  = in_query_tag;
    cls.oor  = (in_position >= len_eff);
    if (in_cmd == CMD_LOCATE) begin
      cls.op = OP_LOCATE;
    end else if (slot_ext < (XW + 1)'(MAX_INTERVALS)) begin
      cls.op = OP_LOAD;
    end else begin
      cls.op = OP_DROP;
    end
  end

  assign in_ready = (fill_r != CNTW'(Q_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_cmd    = cmd_mem[rd_ptr_r];
  assign q_pos    = pos_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_mem[wr_ptr_r] <= cls;
      pos_mem[wr_ptr_r] <= in_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ilo_back.sv -----
// ilo_back: start table memory and the cursor walk sequencer with the result register.
// Depends on ilo_pkg.
`default_nettype none

module ilo_back #(
  parameter int MAX_INTERVALS = ilo_pkg::DEF_MAX_INTERVALS,
  parameter int POS_BITS      = ilo_pkg::DEF_POS_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  output      logic                        q_ready,
  input  wire ilo_pkg::ilo_cmd_t           q_cmd,
  input  wire logic [POS_BITS-1:0]         q_pos,
  input  wire logic [ilo_pkg::COUNT_W-1:0] interval_count,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [ilo_pkg::TAG_W-1:0]   out_result_tag,
  output      logic [ilo_pkg::SLOT_W-1:0]  out_interval_index,
  output      logic [POS_BITS-1:0]         out_offset,
  output      logic                        out_out_of_range
);
  import ilo_pkg::*;

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int EW    = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
  localparam int XW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  logic [POS_BITS-1:0]  mem [MAX_INTERVALS];
  logic [POS_BITS-1:0]  rdata_r;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 mem_we;

  ilo_bk_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]     c_r, c_nxt;
  logic [IDX_W-1:0]     cursor_r, cursor_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [POS_BITS-1:0]  base_r, base_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic                 oor_r, oor_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0]     out_tag_r, out_tag_nxt;
  logic [SLOT_W-1:0]    out_idx_r, out_idx_nxt;
  logic [POS_BITS-1:0]  out_off_r, out_off_nxt;
  logic                 out_oor_r, out_oor_nxt;

  logic [EW-1:0]        cnt_ext, eff, eff_m1, c_p1, c_p2;
  logic [XW-1:0]        slot_x, c_x;
  logic [IDX_W-1:0]     start_idx;
  logic                 down_step, up_step, has_next, has_next2, out_free;

  always_comb begin
    cnt_ext = EW'(interval_count);
    if (cnt_ext == '0) begin
      eff = EW'(1);
    end else if (cnt_ext > EW'(MAX_INTERVALS)) begin
      eff = EW'(MAX_INTERVALS);
    end else begin
      eff = cnt_ext;
    end
    eff_m1    = eff - 1'b1;
    // stale cursor is clamped to the last interval
    start_idx = (EW'(cursor_r) >= eff) ? eff_m1[IDX_W-1:0] : cursor_r;
    c_p1      = EW'(c_r) + EW'(1);
    c_p2      = EW'(c_r) + EW'(2);
    slot_x    = XW'(q_cmd.slot);
    c_x       = XW'(c_r);
    wr_addr   = slot_x[IDX_W-1:0];
    down_step = (c_r != '0) && (pos_r < rdata_r);
    up_step   = (rdata_r <= pos_r);
    has_next  = (c_p1 < eff);
    has_next2 = (c_p2 < eff);
    out_free  = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_cmd.op == OP_LOCATE) begin
          state_nxt = q_cmd.oor ? BK_DONE : BK_DOWN;
        end
      end
      BK_DOWN: begin
        if (down_step) begin
          state_nxt = BK_DOWN;
        end else if (has_next) begin
          state_nxt = BK_UP;
        end else begin
          state_nxt = BK_DONE;
        end
      end
      BK_UP: begin
        state_nxt = (up_step && has_next2) ? BK_UP : BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs and datapath; rdata_r holds the entry addressed in the previous cycle
  always_comb begin
    q_ready       = (state_r == BK_IDLE);
    mem_we        = 1'b0;
    rd_addr       = c_r;
    c_nxt         = c_r;
    cursor_nxt    = cursor_r;
    pos_nxt       = pos_r;
    base_nxt      = base_r;
    tag_nxt       = tag_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_tag_nxt   = out_tag_r;
    out_idx_nxt   = out_idx_r;
    out_off_nxt   = out_off_r;
    out_oor_nxt   = out_oor_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          mem_we   = (q_cmd.op == OP_LOAD);
          pos_nxt  = q_pos;
          tag_nxt  = q_cmd.tag;
          oor_nxt  = q_cmd.oor;
          base_nxt = '0;
          c_nxt    = start_idx;
          rd_addr  = start_idx;
        end
      end
      BK_DOWN: begin
        if (down_step) begin
          c_nxt   = c_r - 1'b1;
          rd_addr = c_r - 1'b1;
        end else begin
          base_nxt = rdata_r;
          rd_addr  = c_p1[IDX_W-1:0];
        end
      end
      BK_UP: begin
        if (up_step) begin
          c_nxt    = c_p1[IDX_W-1:0];
          base_nxt = rdata_r;
          rd_addr  = c_p2[IDX_W-1:0];
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tag_nxt   = tag_r;
          out_oor_nxt   = oor_r;
          if (oor_r) begin
            out_idx_nxt = '0;
            out_off_nxt = '0;
          end else begin
            out_idx_nxt = c_x[SLOT_W-1:0];
            out_off_nxt = pos_r - base_r;
            cursor_nxt  = c_r;
          end
        end
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_pos;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    pos_r     <= pos_nxt;
    base_r    <= base_nxt;
    tag_r     <= tag_nxt;
    oor_r     <= oor_nxt;
    out_tag_r <= out_tag_nxt;
    out_idx_r <= out_idx_nxt;
    out_off_r <= out_off_nxt;
    out_oor_r <= out_oor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_tag     = out_tag_r;
  assign out_interval_index = out_idx_r;
  assign out_offset         = out_off_r;
  assign out_out_of_range   = out_oor_r;

endmodule

`default_nettype wire

// ----- hw/rtl/interval_locate_offset_core.sv -----
// interval_locate_offset_core: config registers, front queue and back-end walker.
// Depends on ilo_pkg, ilo_front and ilo_back.
//
// Usage: load the start table with cmd = 0 items (entry_index, position = start,
// entry 0 holding start 0), set interval_count and total_length over the APB port
// (index 0 at byte 0, index 1 at byte 4), then send cmd = 1 queries with a tag.
// Each query gives one result (tag, interval index, offset, out_of_range); loads
// give none. Both channels are valid/ready; a transfer happens when both are high.
// Input items pass a two-entry queue into the back end, which reads one table
// entry per cycle through a single memory read port.
// A load is written to the table from the idle state; an out-of-range query goes
// straight to the done state; a located query walks the cursor down, then up while
// later entries allow, before the done state loads the result register. The back
// end takes another queued item only once it is back in the idle state.
// A stalled result receiver holds the result register; the queue keeps taking items
// until it is full. Reset empties the queue and result register, sets the cursor
// to 0 and both registers to 1; the start table is not cleared.
`default_nettype none

module interval_locate_offset_core #(
  parameter int MAX_INTERVALS = ilo_pkg::DEF_MAX_INTERVALS,
  parameter int POS_BITS      = ilo_pkg::DEF_POS_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        in_cmd,
  input  wire logic [ilo_pkg::SLOT_W-1:0]  in_entry_index,
  input  wire logic [POS_BITS-1:0]         in_position,
  input  wire logic [ilo_pkg::TAG_W-1:0]   in_query_tag,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [ilo_pkg::TAG_W-1:0]   out_result_tag,
  output      logic [ilo_pkg::SLOT_W-1:0]  out_interval_index,
  output      logic [POS_BITS-1:0]         out_offset,
  output      logic                        out_out_of_range,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ilo_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ilo_pkg::DATA_W-1:0]  pwdata,
  output      logic [ilo_pkg::DATA_W-1:0]  prdata,
  output      logic                        pready
);
  import ilo_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0]   length_r, length_nxt;
  logic               cfg_wr;
  logic               reg_sel;

  logic               q_valid, q_ready;
  ilo_cmd_t           q_cmd;
  logic [POS_BITS-1:0] q_pos;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ADDR_W-1];

  always_comb begin
    count_nxt  = count_r;
    length_nxt = length_r;
    prdata     = '0;
    case (reg_sel)
      REG_INTERVAL_COUNT: begin
        prdata = DATA_W'(count_r);
        if (cfg_wr) begin
          count_nxt = pwdata[COUNT_W-1:0];
        end
      end
      REG_TOTAL_LENGTH: begin
        prdata = DATA_W'(length_r);
        if (cfg_wr) begin
          length_nxt = pwdata[LEN_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= COUNT_W'(1);
      length_r <= LEN_W'(1);
    end else begin
      count_r  <= count_nxt;
      length_r <= length_nxt;
    end
  end

  ilo_front #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .POS_BITS      (POS_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_entry_index (in_entry_index),
    .in_position    (in_position),
    .in_query_tag   (in_query_tag),
    .total_length   (length_r),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_cmd          (q_cmd),
    .q_pos          (q_pos)
  );

  ilo_back #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .POS_BITS      (POS_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_cmd              (q_cmd),
    .q_pos              (q_pos),
    .interval_count     (count_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_tag     (out_result_tag),
    .out_interval_index (out_interval_index),
    .out_offset         (out_offset),
    .out_out_of_range   (out_out_of_range)
  );

endmodule

`default_nettype wire
